// ===== rtl/tce_pkg.sv =====
// Shared types, constants and the fixed micro-program of the tetrad covariance block
package tce_pkg;

    localparam int SCR_W    = 54;
    localparam int ACC_W    = 104;
    localparam int CHUNK_W  = 27;
    localparam int SCR_AW   = 6;
    localparam int SCR_DEPTH = 50;
    localparam int LD_COUNT = 24;
    localparam int PROG_LEN = 102;
    localparam int PC_W     = 7;

    typedef struct packed {
        logic               op;
        logic        [5:0]  entry_row;
        logic        [5:0]  entry_col;
        logic signed [23:0] entry_value;
        logic        [5:0]  first_p;
        logic        [5:0]  first_q;
        logic        [5:0]  first_r;
        logic        [5:0]  first_s;
        logic        [5:0]  second_u;
        logic        [5:0]  second_v;
        logic        [5:0]  second_w;
        logic        [5:0]  second_z;
    } req_t;

    typedef struct packed {
        logic signed [63:0] cov_value;
        logic               saturated;
    } rsp_t;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // index selectors into a query
    localparam logic [2:0] SEL_P = 3'd0;
    localparam logic [2:0] SEL_Q = 3'd1;
    localparam logic [2:0] SEL_R = 3'd2;
    localparam logic [2:0] SEL_S = 3'd3;
    localparam logic [2:0] SEL_U = 3'd4;
    localparam logic [2:0] SEL_V = 3'd5;
    localparam logic [2:0] SEL_W = 3'd6;
    localparam logic [2:0] SEL_Z = 3'd7;

    localparam logic [2:0] LD_ROW_SEL [LD_COUNT] = '{
        SEL_P, SEL_P, SEL_Q, SEL_Q,
        SEL_U, SEL_U, SEL_V, SEL_V,
        SEL_P, SEL_P, SEL_Q, SEL_Q,
        SEL_R, SEL_R, SEL_S, SEL_S,
        SEL_P, SEL_P, SEL_Q, SEL_Q,
        SEL_R, SEL_R, SEL_S, SEL_S
    };

    localparam logic [2:0] LD_COL_SEL [LD_COUNT] = '{
        SEL_R, SEL_S, SEL_R, SEL_S,
        SEL_W, SEL_Z, SEL_W, SEL_Z,
        SEL_U, SEL_V, SEL_U, SEL_V,
        SEL_W, SEL_Z, SEL_W, SEL_Z,
        SEL_W, SEL_Z, SEL_W, SEL_Z,
        SEL_U, SEL_V, SEL_U, SEL_V
    };

    localparam logic [1:0] OP_MAC   = 2'd0;
    localparam logic [1:0] OP_STORE = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [SCR_AW-1:0] a;
        logic [SCR_AW-1:0] b;
        logic              first;
        logic              sub;
    } instr_t;

    typedef instr_t [PROG_LEN-1:0] prog_t;

    typedef struct packed {
        logic       clear;
        logic       mul_en;
        logic [1:0] chunk;
        logic       sub;
        logic       rnd;
    } mac_ctrl_t;

    localparam logic [SCR_AW-1:0] SLOT_D1 = 6'd48;
    localparam logic [SCR_AW-1:0] SLOT_D2 = 6'd49;

    function automatic logic [SCR_AW-1:0] slot_ab(int a, int b);
        return SCR_AW'(a * 2 + b);
    endfunction

    function automatic logic [SCR_AW-1:0] slot_cd(int c, int d);
        return SCR_AW'(4 + c * 2 + d);
    endfunction

    function automatic logic [SCR_AW-1:0] slot_ac(int a, int c);
        return SCR_AW'(8 + a * 2 + c);
    endfunction

    function automatic logic [SCR_AW-1:0] slot_bd(int b, int d);
        return SCR_AW'(12 + b * 2 + d);
    endfunction

    function automatic logic [SCR_AW-1:0] slot_ad(int a, int d);
        return SCR_AW'(16 + a * 2 + d);
    endfunction

    function automatic logic [SCR_AW-1:0] slot_bc(int b, int c);
        return SCR_AW'(20 + b * 2 + c);
    endfunction

    // fourth moment m(a,b,c,d), a in {p,q}, b in {r,s}, c in {u,v}, d in {w,z}
    function automatic logic [SCR_AW-1:0] slot_m(int a, int b, int c, int d);
        return SCR_AW'(24 + (a * 2 + c) * 4 + b * 2 + d);
    endfunction

    // S(p,b)S(v,d)
    function automatic logic [SCR_AW-1:0] slot_pv(int b, int d);
        return SCR_AW'(40 + b * 2 + d);
    endfunction

    // S(u,d)S(q,b)
    function automatic logic [SCR_AW-1:0] slot_uq(int b, int d);
        return SCR_AW'(44 + b * 2 + d);
    endfunction

    function automatic instr_t mk(logic [1:0] op, logic [SCR_AW-1:0] a,
                                  logic [SCR_AW-1:0] b, logic first, logic sub);
        instr_t i;
        i.op    = op;
        i.a     = a;
        i.b     = b;
        i.first = first;
        i.sub   = sub;
        return i;
    endfunction

    function automatic prog_t build_prog();
        prog_t pg;
        int    n;
        pg = '0;
        n  = 0;
        for (int a = 0; a < 2; a++) begin
            for (int c = 0; c < 2; c++) begin
                for (int b = 0; b < 2; b++) begin
                    for (int d = 0; d < 2; d++) begin
                        pg[n] = mk(OP_MAC, slot_ab(a, b), slot_cd(c, d), 1'b1, 1'b0);
                        pg[n + 1] = mk(OP_MAC, slot_ac(a, c), slot_bd(b, d), 1'b0, 1'b0);
                        pg[n + 2] = mk(OP_MAC, slot_ad(a, d), slot_bc(b, c), 1'b0, 1'b0);
                        pg[n + 3] = mk(OP_STORE, slot_m(a, b, c, d), '0, 1'b0, 1'b0);
                        n = n + 4;
                    end
                end
            end
        end
        for (int b = 0; b < 2; b++) begin
            for (int d = 0; d < 2; d++) begin
                pg[n]     = mk(OP_MAC, slot_ab(0, b), slot_cd(1, d), 1'b1, 1'b0);
                pg[n + 1] = mk(OP_STORE, slot_pv(b, d), '0, 1'b0, 1'b0);
                pg[n + 2] = mk(OP_MAC, slot_cd(0, d), slot_ab(1, b), 1'b1, 1'b0);
                pg[n + 3] = mk(OP_STORE, slot_uq(b, d), '0, 1'b0, 1'b0);
                n = n + 4;
            end
        end
        pg[n]     = mk(OP_MAC, slot_ab(0, 0), slot_ab(1, 1), 1'b1, 1'b0);
        pg[n + 1] = mk(OP_MAC, slot_ab(0, 1), slot_ab(1, 0), 1'b0, 1'b1);
        pg[n + 2] = mk(OP_STORE, SLOT_D1, '0, 1'b0, 1'b0);
        pg[n + 3] = mk(OP_MAC, slot_cd(0, 0), slot_cd(1, 1), 1'b1, 1'b0);
        pg[n + 4] = mk(OP_MAC, slot_cd(0, 1), slot_cd(1, 0), 1'b0, 1'b1);
        pg[n + 5] = mk(OP_STORE, SLOT_D2, '0, 1'b0, 1'b0);
        n = n + 6;
        for (int b = 0; b < 2; b++) begin
            for (int d = 0; d < 2; d++) begin
                pg[n] = mk(OP_MAC, slot_m(0, b, 0, d), slot_m(1, 1 - b, 1, 1 - d),
                           (n == 86) ? 1'b1 : 1'b0, 1'((b + d) % 2));
                n = n + 1;
            end
        end
        for (int b = 0; b < 2; b++) begin
            for (int d = 0; d < 2; d++) begin
                pg[n] = mk(OP_MAC, slot_pv(b, 1 - d), slot_m(1, 1 - b, 0, d),
                           1'b0, 1'((b + d) % 2));
                n = n + 1;
            end
        end
        for (int b = 0; b < 2; b++) begin
            for (int d = 0; d < 2; d++) begin
                pg[n] = mk(OP_MAC, slot_uq(1 - b, d), slot_m(0, b, 1, 1 - d),
                           1'b0, 1'((b + d) % 2));
                n = n + 1;
            end
        end
        for (int k = 0; k < 3; k++) begin
            pg[n] = mk(OP_MAC, SLOT_D1, SLOT_D2, 1'b0, 1'b1);
            n = n + 1;
        end
        pg[n] = mk(OP_END, '0, '0, 1'b0, 1'b0);
        return pg;
    endfunction

    localparam prog_t PROG = build_prog();

    function automatic logic [5:0] sel_index(req_t q, logic [2:0] sel);
        logic [5:0] r;
        case (sel)
            SEL_P:   r = q.first_p;
            SEL_Q:   r = q.first_q;
            SEL_R:   r = q.first_r;
            SEL_S:   r = q.first_s;
            SEL_U:   r = q.second_u;
            SEL_V:   r = q.second_v;
            SEL_W:   r = q.second_w;
            SEL_Z:   r = q.second_z;
            default: r = q.first_p;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/tetrad_covariance_entry.sv =====
// Top level: request handling, micro-sequencer and scratch store of the tetrad covariance block
//
// Request channel (req_valid/req_ready/req): a write transaction (op 0) stores one
// Q8.16 matrix entry in the cycle it is accepted and returns nothing. A query
// transaction (op 1) gathers the 24 matrix entries it needs, then runs a fixed
// micro-program of 75 multiply-accumulates and 26 stores on one shared 28x28
// multiplier (four partial products per operation). Result channel
// (rsp_valid/rsp_ready/rsp): one Q32.32 value with a saturation flag per query,
// given after the gather, the micro-program and a rounding step.
// req_ready is high only while the sequencer is idle; a query ties the block up
// until its result is loaded into the output register. A waiting result does not
// stop new requests; a finished query holds in its last step while rsp is stalled.
// Reset clears the control state; matrix entries are undefined until written.
// Indices at or beyond NUM_VARS read as zero, and writes to them are dropped.
module tetrad_covariance_entry
    import tce_pkg::*;
#(
    parameter int NUM_VARS = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int AW = $clog2(NUM_VARS * NUM_VARS);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_LOAD    = 3'd1;
    localparam logic [2:0] ST_FETCH_A = 3'd2;
    localparam logic [2:0] ST_FETCH_B = 3'd3;
    localparam logic [2:0] ST_MUL     = 3'd4;
    localparam logic [2:0] ST_DRAIN   = 3'd5;
    localparam logic [2:0] ST_ROUND   = 3'd6;
    localparam logic [2:0] ST_OUT     = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [4:0]        ld_cnt_reg, ld_cnt_next;
    logic [1:0]        chunk_reg, chunk_next;
    logic              ld_vld_reg, ld_vld_next;
    logic [SCR_AW-1:0] ld_slot_reg;
    logic              ld_zero_reg;
    logic              rsp_valid_reg, rsp_valid_next;
    req_t              query_reg;
    rsp_t              rsp_reg;
    logic [SCR_W-1:0]  opa_reg;

    logic              acc_fire;
    logic              wr_fire;
    logic [AW-1:0]     wr_addr;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [23:0]       rd_data;
    logic [5:0]        ld_row;
    logic [5:0]        ld_col;
    logic              ld_in_range;
    instr_t            instr;
    mac_ctrl_t         mac_ctrl;
    logic [SCR_W-1:0]  acc_low;
    rsp_t              mac_result;

    logic [SCR_W-1:0]  scr_mem [SCR_DEPTH];
    logic [SCR_W-1:0]  scr_rdata;
    logic              scr_re;
    logic [SCR_AW-1:0] scr_raddr;
    logic              scr_store;
    logic              out_load;

    assign req_ready = (state_reg == ST_IDLE);
    assign acc_fire  = req_valid && req_ready;
    assign wr_fire   = acc_fire && (req.op == REQ_WRITE)
                       && (int'(req.entry_row) < NUM_VARS)
                       && (int'(req.entry_col) < NUM_VARS);
    assign wr_addr   = AW'(AW'(req.entry_row) * AW'(NUM_VARS) + AW'(req.entry_col));

    assign ld_row      = sel_index(query_reg, LD_ROW_SEL[ld_cnt_reg]);
    assign ld_col      = sel_index(query_reg, LD_COL_SEL[ld_cnt_reg]);
    assign ld_in_range = (int'(ld_row) < NUM_VARS) && (int'(ld_col) < NUM_VARS);
    assign rd_addr     = AW'(AW'(ld_row) * AW'(NUM_VARS) + AW'(ld_col));
    assign rd_en       = (state_reg == ST_LOAD);

    assign instr = PROG[pc_reg];

    tce_entry_ram #(
        .NUM_VARS (NUM_VARS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_fire),
        .wr_addr (wr_addr),
        .wr_data (req.entry_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tce_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .opa     (opa_reg),
        .opb     (scr_rdata),
        .acc_low (acc_low),
        .result  (mac_result)
    );

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        ld_cnt_next    = ld_cnt_reg;
        chunk_next     = chunk_reg;
        ld_vld_next    = 1'b0;
        rsp_valid_next = rsp_valid_reg;
        mac_ctrl       = '0;
        scr_re         = 1'b0;
        scr_raddr      = instr.a;
        scr_store      = 1'b0;
        out_load       = 1'b0;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (acc_fire && (req.op == REQ_QUERY))
                begin
                    state_next  = ST_LOAD;
                    ld_cnt_next = '0;
                end
            end
            ST_LOAD:
            begin
                ld_vld_next = 1'b1;
                ld_cnt_next = ld_cnt_reg + 5'd1;
                if (ld_cnt_reg == 5'(LD_COUNT - 1))
                begin
                    state_next = ST_FETCH_A;
                    pc_next    = '0;
                end
            end
            ST_FETCH_A:
            begin
                case (instr.op)
                    OP_MAC:
                    begin
                        scr_re         = 1'b1;
                        mac_ctrl.clear = instr.first;
                        state_next     = ST_FETCH_B;
                    end
                    OP_STORE:
                    begin
                        scr_store = 1'b1;
                        pc_next   = pc_reg + 7'd1;
                    end
                    default:
                    begin
                        state_next = ST_ROUND;
                    end
                endcase
            end
            ST_FETCH_B:
            begin
                scr_re     = 1'b1;
                scr_raddr  = instr.b;
                chunk_next = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.chunk  = chunk_reg;
                mac_ctrl.sub    = instr.sub;
                chunk_next      = chunk_reg + 2'd1;
                if (chunk_reg == 2'd3)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                pc_next    = pc_reg + 7'd1;
                state_next = ST_FETCH_A;
            end
            ST_ROUND:
            begin
                mac_ctrl.rnd = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    out_load       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            ld_cnt_reg    <= '0;
            chunk_reg     <= '0;
            ld_vld_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            ld_cnt_reg    <= ld_cnt_next;
            chunk_reg     <= chunk_next;
            ld_vld_reg    <= ld_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_fire)
        begin
            query_reg <= req;
        end
        if (state_reg == ST_LOAD)
        begin
            ld_slot_reg <= SCR_AW'(ld_cnt_reg);
            ld_zero_reg <= !ld_in_range;
        end
        if (state_reg == ST_FETCH_B)
        begin
            opa_reg <= scr_rdata;
        end
        if (out_load)
        begin
            rsp_reg <= mac_result;
        end
    end

    // scratch store
    always_ff @(posedge clk)
    begin
        if (ld_vld_reg)
        begin
            scr_mem[ld_slot_reg] <= ld_zero_reg ? '0
                                    : {{(SCR_W-24){rd_data[23]}}, rd_data};
        end
        else if (scr_store)
        begin
            scr_mem[instr.a] <= acc_low;
        end
        if (scr_re)
        begin
            scr_rdata <= scr_mem[scr_raddr];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/tce_entry_ram.sv =====
// Matrix entry store: one write port, one registered read port
module tce_entry_ram
    import tce_pkg::*;
#(
    parameter int NUM_VARS = 64
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [$clog2(NUM_VARS*NUM_VARS)-1:0]    wr_addr,
    input  logic [23:0]                             wr_data,
    input  logic                                    rd_en,
    input  logic [$clog2(NUM_VARS*NUM_VARS)-1:0]    rd_addr,
    output logic [23:0]                             rd_data
);

    localparam int DEPTH = NUM_VARS * NUM_VARS;

    logic [23:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/tce_mac.sv =====
// Shared multiply-accumulate unit: 28x28 partial products, wide accumulator, rounding
module tce_mac
    import tce_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  mac_ctrl_t        ctrl,
    input  logic [SCR_W-1:0] opa,
    input  logic [SCR_W-1:0] opb,
    output logic [SCR_W-1:0] acc_low,
    output rsp_t             result
);

    localparam logic [ACC_W-1:0] HALF = ACC_W'(64'h8000_0000);

    logic signed [27:0]  a_part;
    logic signed [27:0]  b_part;
    logic signed [55:0]  prod;
    logic [55:0]         prod_reg;
    logic [1:0]          pchunk_reg;
    logic                psub_reg;
    logic                pvld_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [ACC_W-1:0]    acc_next;
    logic [ACC_W-1:0]    ext;
    logic [ACC_W-1:0]    addend;
    logic [ACC_W-1:0]    rnd_reg;
    logic [8:0]          top;
    logic                sat;

    assign a_part = ctrl.chunk[0] ? {opa[SCR_W-1], opa[SCR_W-1:CHUNK_W]}
                                  : {1'b0, opa[CHUNK_W-1:0]};
    assign b_part = ctrl.chunk[1] ? {opb[SCR_W-1], opb[SCR_W-1:CHUNK_W]}
                                  : {1'b0, opb[CHUNK_W-1:0]};
    assign prod   = a_part * b_part;

    assign ext = {{(ACC_W-56){prod_reg[55]}}, prod_reg};

    always_comb
    begin
        case (pchunk_reg)
            2'b00:   addend = ext;
            2'b01:   addend = ext << CHUNK_W;
            2'b10:   addend = ext << CHUNK_W;
            default: addend = ext << (2 * CHUNK_W);
        endcase
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (pvld_reg)
        begin
            acc_next = psub_reg ? acc_reg - addend : acc_reg + addend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvld_reg <= 1'b0;
        end
        else
        begin
            pvld_reg <= ctrl.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg   <= prod;
            pchunk_reg <= ctrl.chunk;
            psub_reg   <= ctrl.sub;
        end
        acc_reg <= acc_next;
        if (ctrl.rnd)
        begin
            rnd_reg <= acc_reg + HALF;
        end
    end

    assign acc_low = acc_reg[SCR_W-1:0];

    assign top = rnd_reg[ACC_W-1:95];
    assign sat = !((&top) || !(|top));

    always_comb
    begin
        result.saturated = sat;
        if (!sat)
        begin
            result.cov_value = rnd_reg[95:32];
        end
        else if (rnd_reg[ACC_W-1])
        begin
            result.cov_value = {1'b1, 63'd0};
        end
        else
        begin
            result.cov_value = {1'b0, {63{1'b1}}};
        end
    end

endmodule

// ===== bench/tetrad_covariance_entry_test.sv =====
// Self-checking testbench for the tetrad covariance entry block
`timescale 1ns / 100ps

module tetrad_covariance_entry_test;
    import tce_pkg::*;

    localparam int NVARS = 64;
    localparam int RANDOM_ITEMS = 2000;
    localparam int POOL_MAX = 24;
    localparam int REQ_BITS = $bits(req_t);
    localparam logic signed [127:0] COV_MAX = (128'sd1 <<< 63) - 128'sd1;
    localparam logic signed [127:0] COV_MIN = -(128'sd1 <<< 63);

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    logic signed [23:0] matrix_copy [NVARS][NVARS];
    bit                 in_pool [NVARS];
    int                 pool [$];
    rsp_t               cov_expected [$];
    int                 errors;
    int                 items_sent;
    int                 send_idle_pct;
    int                 recv_stall_pct;

    tetrad_covariance_entry #(.NUM_VARS(NVARS)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic signed [127:0] entry_at(int a, int b);
        return 128'(matrix_copy[a][b]);
    endfunction

    function automatic logic signed [127:0] moment4(int a, int b, int c, int d);
        return entry_at(a, b) * entry_at(c, d) + entry_at(a, c) * entry_at(b, d)
             + entry_at(a, d) * entry_at(b, c);
    endfunction

    function automatic rsp_t tetrad_cov(req_t t);
        logic signed [127:0] acc;
        logic signed [127:0] d1;
        logic signed [127:0] d2;
        int p, q, r, s, u, v, w, z;
        rsp_t res;
        p = t.first_p;  q = t.first_q;  r = t.first_r;  s = t.first_s;
        u = t.second_u; v = t.second_v; w = t.second_w; z = t.second_z;
        acc = 0;
        acc += moment4(p, r, u, w) * moment4(q, s, v, z);
        acc -= moment4(p, r, u, z) * moment4(q, s, v, w);
        acc -= moment4(p, s, u, w) * moment4(q, r, v, z);
        acc += moment4(p, s, u, z) * moment4(q, r, v, w);
        acc += entry_at(p, r) * entry_at(v, z) * moment4(q, s, u, w);
        acc -= entry_at(p, r) * entry_at(v, w) * moment4(q, s, u, z);
        acc -= entry_at(p, s) * entry_at(v, z) * moment4(q, r, u, w);
        acc += entry_at(p, s) * entry_at(v, w) * moment4(q, r, u, z);
        acc += entry_at(u, w) * entry_at(q, s) * moment4(p, r, v, z);
        acc -= entry_at(u, z) * entry_at(q, s) * moment4(p, r, v, w);
        acc -= entry_at(u, w) * entry_at(q, r) * moment4(p, s, v, z);
        acc += entry_at(u, z) * entry_at(q, r) * moment4(p, s, v, w);
        d1 = entry_at(p, r) * entry_at(q, s) - entry_at(p, s) * entry_at(q, r);
        d2 = entry_at(u, w) * entry_at(v, z) - entry_at(u, z) * entry_at(v, w);
        acc -= 128'sd3 * d1 * d2;
        acc = (acc + (128'sd1 <<< 31)) >>> 32;
        res.saturated = 1'b0;
        if (acc > COV_MAX)
        begin
            acc = COV_MAX;
            res.saturated = 1'b1;
        end
        else if (acc < COV_MIN)
        begin
            acc = COV_MIN;
            res.saturated = 1'b1;
        end
        res.cov_value = acc[63:0];
        return res;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_item(req_t item);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        req_valid = 1'b1;
        req = item;
        do
            @(posedge clk);
        while (!req_ready);
        if (item.op == REQ_WRITE)
            matrix_copy[item.entry_row][item.entry_col] = item.entry_value;
        else
            cov_expected.push_back(tetrad_cov(item));
        items_sent++;
        @(negedge clk);
        req_valid = 1'b0;
        req = REQ_BITS'({$urandom, $urandom, $urandom});
    endtask

    function automatic logic signed [23:0] pick_value();
        case ($urandom_range(7))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'sd0;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic write_entry(int row, int col, logic signed [23:0] val);
        req_t item;
        item = REQ_BITS'({$urandom, $urandom, $urandom});
        item.op = REQ_WRITE;
        item.entry_row = 6'(row);
        item.entry_col = 6'(col);
        item.entry_value = val;
        send_item(item);
    endtask

    task automatic add_to_pool(int k);
        foreach (pool[i])
        begin
            write_entry(k, pool[i], pick_value());
            write_entry(pool[i], k, pick_value());
        end
        write_entry(k, k, pick_value());
        pool.push_back(k);
        in_pool[k] = 1'b1;
    endtask

    task automatic query(int p, int q, int r, int s, int u, int v, int w, int z);
        req_t item;
        item = REQ_BITS'({$urandom, $urandom, $urandom});
        item.op = REQ_QUERY;
        item.first_p = 6'(p);  item.first_q = 6'(q);
        item.first_r = 6'(r);  item.first_s = 6'(s);
        item.second_u = 6'(u); item.second_v = 6'(v);
        item.second_w = 6'(w); item.second_z = 6'(z);
        send_item(item);
    endtask

    function automatic int pool_pick();
        return pool[$urandom_range(pool.size() - 1)];
    endfunction

    task automatic random_query();
        query(pool_pick(), pool_pick(), pool_pick(), pool_pick(),
              pool_pick(), pool_pick(), pool_pick(), pool_pick());
    endtask

    task automatic drain();
        while (cov_expected.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        add_to_pool(0);
        add_to_pool(63);
        add_to_pool(21);
        add_to_pool(42);
        query(0, 0, 0, 0, 0, 0, 0, 0);
        query(63, 63, 63, 63, 63, 63, 63, 63);
        query(0, 63, 21, 42, 42, 21, 63, 0);
        query(21, 42, 0, 63, 63, 0, 42, 21);
        foreach (pool[i])
            foreach (pool[j])
                write_entry(pool[i], pool[j], ($urandom_range(1) != 0) ? 24'sh7FFFFF : 24'sh800000);
        query(0, 63, 21, 42, 21, 0, 42, 63);
        query(63, 21, 0, 42, 42, 63, 21, 0);
        drain();
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        int stop_at;
        int k;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: random_query();
                5, 6, 7: write_entry(pool_pick(), pool_pick(), pick_value());
                8: write_entry($urandom_range(NVARS - 1), $urandom_range(NVARS - 1),
                               pick_value());
                default:
                begin
                    k = $urandom_range(NVARS - 1);
                    if (pool.size() < POOL_MAX && !in_pool[k])
                        add_to_pool(k);
                    else
                        random_query();
                end
            endcase
        end
    endtask

    task automatic test_paused_sender();
        random_query();
        random_query();
        drain();
        repeat (20) @(negedge clk);
        random_query();
    endtask

    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (cov_expected.size() == 0)
            begin
                $error("unexpected result transaction: cov_value %h", rsp.cov_value);
                errors++;
            end
            else
            begin
                if (rsp.cov_value !== cov_expected[0].cov_value)
                begin
                    $error("cov_value: expected %h, actual %h",
                           cov_expected[0].cov_value, rsp.cov_value);
                    errors++;
                end
                if (rsp.saturated !== cov_expected[0].saturated)
                begin
                    $error("saturated: expected %b, actual %b",
                           cov_expected[0].saturated, rsp.saturated);
                    errors++;
                end
                void'(cov_expected.pop_front());
            end
        end
    end

    initial
    begin
        errors = 0;
        items_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        req_valid = 1'b0;
        req = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random(500, 0, 0);
        test_paused_sender();
        test_random(500, 69, 0);
        test_random(500, 0, 69);
        test_random(500, 28, 28);
        drain();
        repeat (700) @(negedge clk);
        if (errors == 0 && cov_expected.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tce_pkg.sv
rtl/tce_entry_ram.sv
rtl/tce_mac.sv
rtl/tetrad_covariance_entry.sv
bench/tetrad_covariance_entry_test.sv
